// ===== src/spom_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spom_pkg
// Shared types and constants of the spiral order matrix reader.
// ----------------------------------------------------------------------------
package spom_pkg;

	// Default matrix size limits, used by the top level parameters.
	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 32;

	// Dimension registers are six bits wide, so no more than 63 rows or columns.
	localparam int DIM_W   = 6;
	localparam int DIM_MAX = 63;

	// Element counters cover up to 63 * 63 elements.
	localparam int CNT_W = 12;

	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 4'd1;

	// Item operations.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FINISHED  = 2'd2;

	// Direction of travel along the spiral.
	typedef enum logic [3:0] {
		HEAD_RIGHT = 4'b0001,
		HEAD_DOWN  = 4'b0010,
		HEAD_LEFT  = 4'b0100,
		HEAD_UP    = 4'b1000
	} heading_t;

	// Response of a request item, given in the cycle after it is accepted.
	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic                last;
	} rsp_t;

endpackage

// ===== src/spom_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spom_store
// Matrix element memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module spom_store import spom_pkg::*; #(
	parameter int DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF,
	parameter int AW    = 10
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/spom_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spom_ctrl
// Load position, spiral cursor with its four bounds, and response decision.
// ----------------------------------------------------------------------------
module spom_ctrl import spom_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int AW       = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_acc,
	input  logic                 op,
	input  logic [DATA_W-1:0]    value,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [DATA_W-1:0]    wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	output rsp_t                 rsp_s1
);

	localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_LIM = (MAX_ROWS < DIM_MAX) ? MAX_ROWS : DIM_MAX;
	localparam int COL_LIM = (MAX_COLS < DIM_MAX) ? MAX_COLS : DIM_MAX;

	logic [DIM_W-1:0] row_count_q, col_count_q;
	logic [DIM_W-1:0] rows_used, cols_used;
	logic [CNT_W-1:0] total;

	logic             full_q;
	logic [RW-1:0]    load_row_q, load_row;
	logic [CW-1:0]    load_col_q, load_col;
	logic [RW-1:0]    row_last;
	logic [CW-1:0]    col_last;

	logic [CNT_W-1:0] emit_count_q;
	logic [RW-1:0]    top_q, bottom_q, cur_row_q;
	logic [CW-1:0]    left_q, right_q, cur_col_q;
	heading_t         heading_q;

	logic             do_load, do_req, emit_ok, load_end;

	// Dimensions outside the supported range are used as the nearest legal value.
	always_comb begin
		if (row_count_q == '0) begin
			rows_used = DIM_W'(1);
		end else if (row_count_q > DIM_W'(ROW_LIM)) begin
			rows_used = DIM_W'(ROW_LIM);
		end else begin
			rows_used = row_count_q;
		end
		if (col_count_q == '0) begin
			cols_used = DIM_W'(1);
		end else if (col_count_q > DIM_W'(COL_LIM)) begin
			cols_used = DIM_W'(COL_LIM);
		end else begin
			cols_used = col_count_q;
		end
	end

	assign total    = CNT_W'(rows_used) * CNT_W'(cols_used);
	assign row_last = RW'(rows_used - DIM_W'(1));
	assign col_last = CW'(cols_used - DIM_W'(1));

	// A load on a full matrix starts a new one at the top-left corner.
	assign load_row = full_q ? '0 : load_row_q;
	assign load_col = full_q ? '0 : load_col_q;
	assign load_end = (load_row == row_last) && (load_col == col_last);

	assign do_load = item_acc && (op == OP_LOAD);
	assign do_req  = item_acc && (op == OP_REQUEST);
	assign emit_ok = do_req && full_q && (emit_count_q != total);

	assign wr_en   = do_load;
	assign wr_addr = AW'(load_row) * AW'(MAX_COLS) + AW'(load_col);
	assign wr_data = value;
	assign rd_en   = emit_ok;
	assign rd_addr = AW'(cur_row_q) * AW'(MAX_COLS) + AW'(cur_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= DIM_W'(1);
			col_count_q  <= DIM_W'(1);
			full_q       <= 1'b0;
			load_row_q   <= '0;
			load_col_q   <= '0;
			emit_count_q <= '0;
			top_q        <= '0;
			bottom_q     <= '0;
			left_q       <= '0;
			right_q      <= '0;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			heading_q    <= HEAD_RIGHT;
			rsp_s1       <= '0;
		end else begin
			rsp_s1.valid <= do_req;
			if (do_req) begin
				if (!full_q) begin
					rsp_s1.status <= ST_NOT_READY;
					rsp_s1.last   <= 1'b0;
				end else if (!emit_ok) begin
					rsp_s1.status <= ST_FINISHED;
					rsp_s1.last   <= 1'b0;
				end else begin
					rsp_s1.status <= ST_OK;
					rsp_s1.last   <= (emit_count_q + CNT_W'(1)) == total;
				end
			end

			if (cfg_we) begin
				if (cfg_index == CFG_ROW_COUNT || cfg_index == CFG_COL_COUNT) begin
					if (cfg_index == CFG_ROW_COUNT) begin
						row_count_q <= cfg_data;
					end else begin
						col_count_q <= cfg_data;
					end
					full_q       <= 1'b0;
					load_row_q   <= '0;
					load_col_q   <= '0;
					emit_count_q <= '0;
				end
			end else if (do_load) begin
				if (load_col == col_last) begin
					load_col_q <= '0;
					load_row_q <= load_row + RW'(1);
				end else begin
					load_col_q <= load_col + CW'(1);
					load_row_q <= load_row;
				end
				full_q <= load_end;
				if (load_end) begin
					top_q        <= '0;
					bottom_q     <= row_last;
					left_q       <= '0;
					right_q      <= col_last;
					cur_row_q    <= '0;
					cur_col_q    <= '0;
					heading_q    <= HEAD_RIGHT;
					emit_count_q <= '0;
				end
			end else if (emit_ok) begin
				emit_count_q <= emit_count_q + CNT_W'(1);
				// At an edge of the open region, turn clockwise and shrink the
				// bound just finished.
				case (heading_q)
					HEAD_RIGHT: begin
						if (cur_col_q < right_q) begin
							cur_col_q <= cur_col_q + CW'(1);
						end else begin
							top_q     <= top_q + RW'(1);
							heading_q <= HEAD_DOWN;
							cur_row_q <= cur_row_q + RW'(1);
						end
					end
					HEAD_DOWN: begin
						if (cur_row_q < bottom_q) begin
							cur_row_q <= cur_row_q + RW'(1);
						end else begin
							right_q   <= right_q - CW'(1);
							heading_q <= HEAD_LEFT;
							cur_col_q <= cur_col_q - CW'(1);
						end
					end
					HEAD_LEFT: begin
						if (cur_col_q > left_q) begin
							cur_col_q <= cur_col_q - CW'(1);
						end else begin
							bottom_q  <= bottom_q - RW'(1);
							heading_q <= HEAD_UP;
							cur_row_q <= cur_row_q - RW'(1);
						end
					end
					default: begin
						if (cur_row_q > top_q) begin
							cur_row_q <= cur_row_q - RW'(1);
						end else begin
							left_q    <= left_q + CW'(1);
							heading_q <= HEAD_RIGHT;
							cur_col_q <= cur_col_q + CW'(1);
						end
					end
				endcase
			end
		end
	end

`ifndef SYNTH
	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		do_req |=> rsp_s1.valid)
		else $error("request item produced no response");

	a_last_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_s1.valid && rsp_s1.last) |-> (rsp_s1.status == ST_OK))
		else $error("last flag on a response without an element");

	a_emit_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		emit_count_q <= total)
		else $error("more elements emitted than the matrix holds");

	a_ok_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> full_q)
		else $error("store read before the matrix was fully loaded");
`endif

endmodule

// ===== src/spiral_order_matrix_reader_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader_top
// Loads a matrix row by row and reads it back in clockwise spiral order.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on a clock edge with start high and busy
//   low. op selects a load (value is stored at the next row-major position)
//   or a request for the next spiral element.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   index 0 sets the row count, index 1 the column count. Either write drops
//   the matrix in progress. cfg_ready is always high.
//   Results: a load gives no result. A request gives exactly one result on
//   element/status/last, marked by a one-cycle strobe, in the cycle after the
//   request is taken. status 0 carries an element, 1 means the matrix is not
//   fully loaded, 2 means the spiral is done; last marks the final element.
//   Throughput: one item per cycle. A request reads the element memory on its
//   single read port, whose registered output feeds the result in the next
//   cycle; loads use the separate write port, so busy never rises.
//   Reset: the dimensions return to one by one and no matrix is loaded. The
//   element memory is not cleared. The receiver cannot stall the results.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader_top import spom_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic signed [DATA_W-1:0]   value,
	output logic                       strobe,
	output logic signed [DATA_W-1:0]   element,
	output logic [STATUS_W-1:0]        status,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [DIM_W-1:0]           cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [DATA_W-1:0] wr_data, rd_data;
	rsp_t              rsp_s1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	spom_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_acc  (start && !busy),
		.op        (op),
		.value     (value),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rsp_s1    (rsp_s1)
	);

	spom_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign strobe  = rsp_s1.valid;
	assign status  = rsp_s1.status;
	assign last    = rsp_s1.last;
	assign element = (rsp_s1.valid && rsp_s1.status == ST_OK) ? rd_data : '0;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the spiral order matrix reader. Matrices are loaded
// row by row and read back by request items. A predictor tracks the matrix and
// the shrinking bounds of the spiral, and each result is compared field by
// field with the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;
	import spom_pkg::*;

	localparam int ROWS_MAX      = MAX_ROWS_DEF;
	localparam int COLS_MAX      = MAX_COLS_DEF;
	localparam int RANDOM_ITEMS  = 750;
	localparam int QUIET_TAIL    = 150;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 400000;

	// No register sits at this index, so a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

	// The old marker value for visited cells; here it is an ordinary element.
	localparam logic signed [DATA_W-1:0] OLD_MARKER = -32'sd9876;
	localparam logic signed [DATA_W-1:0] MOST_NEG   = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MOST_POS   = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct {
		logic signed [DATA_W-1:0] element;
		logic [STATUS_W-1:0]      status;
		logic                     last;
	} spiral_result_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     start     = 1'b0;
	logic                     op        = OP_LOAD;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = CFG_ROW_COUNT;
	logic [DIM_W-1:0]         cfg_data  = '0;
	logic                     busy;
	logic                     strobe;
	logic signed [DATA_W-1:0] element;
	logic [STATUS_W-1:0]      status;
	logic                     last;
	logic                     cfg_ready;

	// Predictor state.
	logic signed [DATA_W-1:0] cell_value [ROWS_MAX][COLS_MAX];
	logic [DIM_W-1:0]         row_setting = DIM_W'(1);
	logic [DIM_W-1:0]         col_setting = DIM_W'(1);
	int                       loads_done  = 0;
	int                       reads_done  = 0;
	int                       top_edge    = 0;
	int                       bottom_edge = 0;
	int                       left_edge   = 0;
	int                       right_edge  = 0;
	int                       row_pos     = 0;
	int                       col_pos     = 0;
	heading_t                 walk_dir    = HEAD_RIGHT;

	spiral_result_t pending_results [$];
	spiral_result_t head_result;
	int             error_count = 0;
	int             items_sent  = 0;
	int             cycle_count = 0;
	bit             quiet       = 1'b0;

	spiral_order_matrix_reader_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.value     (value),
		.strobe    (strobe),
		.element   (element),
		.status    (status),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int effective_dim(input logic [DIM_W-1:0] setting, input int limit);
		if (setting == 0)
			return 1;
		if (int'(setting) > limit)
			return limit;
		return int'(setting);
	endfunction

	function automatic int matrix_size();
		return effective_dim(row_setting, ROWS_MAX) * effective_dim(col_setting, COLS_MAX);
	endfunction

	function automatic logic signed [DATA_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return OLD_MARKER;
			3: return '0;
			4: return -1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] random_dim();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIM_W'($urandom_range(9, DIM_MAX));
			default: return DIM_W'($urandom_range(1, 6));
		endcase
	endfunction

	// Updates the spiral state for one accepted item and, for a request, queues its result.
	task automatic predict_item(input logic item_op, input logic signed [DATA_W-1:0] item_value);
		int             cols;
		int             total;
		spiral_result_t res;
		cols  = effective_dim(col_setting, COLS_MAX);
		total = matrix_size();
		if (item_op == OP_LOAD) begin
			if (loads_done >= total)
				loads_done = 0;
			cell_value[loads_done / cols][loads_done % cols] = item_value;
			loads_done++;
			if (loads_done == total) begin
				top_edge    = 0;
				bottom_edge = effective_dim(row_setting, ROWS_MAX) - 1;
				left_edge   = 0;
				right_edge  = cols - 1;
				row_pos     = 0;
				col_pos     = 0;
				walk_dir    = HEAD_RIGHT;
				reads_done  = 0;
			end
		end else begin
			res.element = '0;
			res.last    = 1'b0;
			if (loads_done < total) begin
				res.status = ST_NOT_READY;
			end else if (reads_done >= total) begin
				res.status = ST_FINISHED;
			end else begin
				res.status  = ST_OK;
				res.element = cell_value[row_pos][col_pos];
				reads_done++;
				res.last = (reads_done == total);
				// At an edge of the unvisited region, turn clockwise and shrink the
				// bound that was just walked along.
				case (walk_dir)
					HEAD_RIGHT: begin
						if (col_pos < right_edge) begin
							col_pos++;
						end else begin
							top_edge++;
							walk_dir = HEAD_DOWN;
							row_pos++;
						end
					end
					HEAD_DOWN: begin
						if (row_pos < bottom_edge) begin
							row_pos++;
						end else begin
							right_edge--;
							walk_dir = HEAD_LEFT;
							col_pos--;
						end
					end
					HEAD_LEFT: begin
						if (col_pos > left_edge) begin
							col_pos--;
						end else begin
							bottom_edge--;
							walk_dir = HEAD_UP;
							row_pos--;
						end
					end
					default: begin
						if (row_pos > top_edge) begin
							row_pos--;
						end else begin
							left_edge++;
							walk_dir = HEAD_RIGHT;
							col_pos++;
						end
					end
				endcase
			end
			pending_results.push_back(res);
		end
	endtask

	// Start is left high on return so that back-to-back items stream.
	task automatic send_item(input logic item_op, input logic signed [DATA_W-1:0] item_value);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		op    <= item_op;
		value <= item_value;
		do @(posedge clk); while (busy);
		predict_item(item_op, item_value);
		items_sent++;
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ROW_COUNT;
		cfg_data  <= rows;
		do @(posedge clk); while (!cfg_ready);
		row_setting = rows;
		loads_done  = 0;
		reads_done  = 0;
		cfg_index <= CFG_COL_COUNT;
		cfg_data  <= cols;
		do @(posedge clk); while (!cfg_ready);
		col_setting = cols;
		loads_done  = 0;
		reads_done  = 0;
		cfg_valid <= 1'b0;
	endtask

	// After reset the matrix is one by one and nothing is loaded.
	task automatic test_reset_state();
		send_item(OP_REQUEST, $urandom());
		send_item(OP_LOAD, random_value());
		send_item(OP_REQUEST, $urandom());
		send_item(OP_REQUEST, $urandom());
		// A load on a full matrix starts the next one.
		send_item(OP_LOAD, random_value());
		send_item(OP_REQUEST, $urandom());
	endtask

	// The old marker value sits on the spiral path and must not act as a wall.
	task automatic test_value_extremes();
		set_dims(DIM_W'(2), DIM_W'(3));
		send_item(OP_LOAD, MOST_NEG);
		send_item(OP_LOAD, OLD_MARKER);
		send_item(OP_LOAD, MOST_POS);
		send_item(OP_REQUEST, $urandom());
		send_item(OP_LOAD, '0);
		send_item(OP_LOAD, OLD_MARKER);
		send_item(OP_LOAD, -1);
		repeat (7) send_item(OP_REQUEST, $urandom());
	endtask

	task automatic test_register_write();
		set_dims(DIM_W'(1), DIM_W'(2));
		send_item(OP_LOAD, random_value());
		// Rewriting a register drops the partly loaded matrix.
		set_dims(DIM_W'(1), DIM_W'(2));
		send_item(OP_REQUEST, $urandom());
		send_item(OP_LOAD, random_value());
		send_item(OP_REQUEST, $urandom());
		send_item(OP_LOAD, random_value());
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_UNUSED;
		cfg_data  <= DIM_W'($urandom_range(0, DIM_MAX));
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		repeat (3) send_item(OP_REQUEST, $urandom());
	endtask

	// The tallest and the widest shapes reach the last row and the last column.
	task automatic test_largest_matrix();
		set_dims(DIM_W'(ROWS_MAX), DIM_W'(2));
		repeat (ROWS_MAX * 2) send_item(OP_LOAD, random_value());
		repeat (ROWS_MAX * 2 + 1) send_item(OP_REQUEST, $urandom());
		set_dims(DIM_W'(2), DIM_W'(COLS_MAX));
		repeat (COLS_MAX * 2) send_item(OP_LOAD, random_value());
		repeat (COLS_MAX * 2 + 1) send_item(OP_REQUEST, $urandom());
	endtask

	// Mostly whole matrices read to the end, with early requests, partial loads,
	// cut-off spirals and size changes mixed in.
	task automatic test_random_spirals();
		int               first_item;
		int               total;
		int               count;
		int               shape;
		logic [DIM_W-1:0] dim_a;
		logic [DIM_W-1:0] dim_b;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			quiet = (items_sent - first_item >= RANDOM_ITEMS - QUIET_TAIL);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				dim_a = random_dim();
				dim_b = (effective_dim(dim_a, ROWS_MAX) > 8) ?
					DIM_W'($urandom_range(0, 2)) : random_dim();
				if ($urandom_range(0, 1) == 0)
					set_dims(dim_a, dim_b);
				else
					set_dims(dim_b, dim_a);
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				wait_results_drained();
			end
			total = matrix_size();
			shape = $urandom_range(0, 9);
			count = (shape == 0) ? $urandom_range(0, total - 1) : total;
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 11) == 0)
					send_item(OP_REQUEST, $urandom());
				send_item(OP_LOAD, random_value());
			end
			if (shape == 0)
				count = $urandom_range(1, 3);
			else if (shape == 1)
				count = $urandom_range(0, total - 1);
			else
				count = total + $urandom_range(0, 2);
			for (int i = 0; i < count; i++)
				send_item(OP_REQUEST, $urandom());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with no request waiting, status %0d element %0d",
					$time, status, element);
				error_count++;
			end else begin
				head_result = pending_results.pop_front();
				if (element !== head_result.element) begin
					$display("%0t ns: element mismatch, expected %0d, actual %0d",
						$time, head_result.element, element);
					error_count++;
				end
				if (status !== head_result.status) begin
					$display("%0t ns: status mismatch, expected %0d, actual %0d",
						$time, head_result.status, status);
					error_count++;
				end
				if (last !== head_result.last) begin
					$display("%0t ns: last mismatch, expected %0b, actual %0b",
						$time, head_result.last, last);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_value_extremes();
		test_register_write();
		test_largest_matrix();
		test_random_spirals();
		wait_results_drained();
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
